// ===== rtl/joint_dynamic_stiffness_core_defines.svh =====
// ---------------------------------------------------------------------------
// Joint dynamic stiffness assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef JOINT_DYNAMIC_STIFFNESS_CORE_DEFINES_SVH
`define JOINT_DYNAMIC_STIFFNESS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define JDS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define JDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define JDS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define JDS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/jds_pkg.sv =====
// ---------------------------------------------------------------------------
// Joint dynamic stiffness package
// Field widths, fixed constants and the per-item flag bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package jds_pkg;

	localparam int STIFF_W = 7;
	localparam int ANGLE_W = 16;
	localparam int ERR_W   = 16;
	localparam int NUM_W   = 43;   // 2 * err * degrees-per-radian
	localparam int QW      = 17;   // quotient bits of r in Q16, below 2.0
	localparam int SQ_W    = 34;
	localparam int PROD_W  = 40;

	localparam logic [25:0]        DEG_PER_RAD_Q20 = 26'd60078979;
	localparam logic [STIFF_W-1:0] WINDOW_BASE     = 7'd101;
	localparam logic [STIFF_W-1:0] STIFF_FULL      = 7'd100;
	localparam logic [STIFF_W-1:0] STIFF_FLOOR     = 7'd10;
	localparam logic [STIFF_W-1:0] STIFF_LIMP      = 7'd0;
	localparam logic [5:0]         CURVE_GAIN      = 6'd45;

	typedef struct packed {
		logic zero;   // limp request
		logic sat;    // window empty, drive full
		logic ovf;    // r at or beyond 2.0
		logic lo;     // r below 1.0
	} flags_t;

endpackage

`default_nettype wire

// ===== rtl/joint_dynamic_stiffness_core.sv =====
// ---------------------------------------------------------------------------
// Joint dynamic stiffness core
// Maps requested stiffness and angle error of one joint to the drive stiffness.
// ---------------------------------------------------------------------------
// One joint is taken per transfer and one stiffness result comes out per
// joint, in order. The block accepts a new joint in every cycle unless
// stalled, and has three front stages (error, scaling multiply, range
// check), a 17-stage restoring divider that produces one quotient bit per
// stage against the window, and four back stages (curve select, square,
// gain, final result register). The whole pipeline holds while a finished
// result waits on out_ready; nothing is dropped or repeated across a stall.
// A requested stiffness of 0 drives 0, stiffness of 101 or more drives 100,
// otherwise the result is 0.1 + 0.45r^2 or 1 - 0.45(r-2)^2 scaled to whole
// percent, with r = 2|error| / (101 - stiffness) degrees.
`default_nettype none
`include "joint_dynamic_stiffness_core_defines.svh"

module joint_dynamic_stiffness_core
	import jds_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [STIFF_W-1:0]        requested_stiffness,
	input  wire logic signed [ANGLE_W-1:0] requested_angle,
	input  wire logic signed [ANGLE_W-1:0] measured_angle,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [STIFF_W-1:0]             applied_stiffness
);

	// Quotient is taken straight in Q16: divide by window << SH.
	localparam int SH = ANGLE_FRAC_BITS + 4;

	// Advance every stage together; hold everything while the result stalls.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- Stage 1: window and absolute error ----------------
	logic signed [ANGLE_W:0] diff_c;
	logic [ANGLE_W:0]        diff_mag_c;
	assign diff_c     = {requested_angle[ANGLE_W-1], requested_angle}
	                  - {measured_angle[ANGLE_W-1], measured_angle};
	assign diff_mag_c = diff_c[ANGLE_W] ? (~diff_c + 1'b1) : diff_c;

	logic               v_s1;
	flags_t             f_s1;
	logic [STIFF_W-1:0] w_s1;
	logic [ERR_W-1:0]   err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1.zero <= (requested_stiffness == STIFF_LIMP);
			f_s1.sat  <= (requested_stiffness >= WINDOW_BASE);
			f_s1.ovf  <= 1'b0;
			f_s1.lo   <= 1'b0;
			w_s1      <= WINDOW_BASE - requested_stiffness;
			err_s1    <= diff_mag_c[ERR_W-1:0];
		end
	end

	// ---------------- Stage 2: scale error to degrees, doubled ----------------
	logic [NUM_W-1:0] num_c;
	assign num_c = (NUM_W'(err_s1) * NUM_W'(DEG_PER_RAD_Q20)) << 1;

	logic               v_s2;
	flags_t             f_s2;
	logic [STIFF_W-1:0] w_s2;
	logic [NUM_W-1:0]   num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s2   <= f_s1;
			w_s2   <= w_s1;
			num_s2 <= num_c;
		end
	end

	// ---------------- Stage 3: flag r >= 2.0 before dividing ----------------
	logic [NUM_W-1:0] top_dvs_c;
	assign top_dvs_c = NUM_W'(w_s2) << (SH + QW);

	logic               v_s3;
	flags_t             f_s3;
	logic [STIFF_W-1:0] w_s3;
	logic [NUM_W-1:0]   rem_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s3.zero <= f_s2.zero;
			f_s3.sat  <= f_s2.sat;
			f_s3.ovf  <= (num_s2 >= top_dvs_c);
			f_s3.lo   <= f_s2.lo;
			w_s3      <= w_s2;
			rem_s3    <= num_s2;
		end
	end

	// ---------------- Stage 4: restoring divider, one bit per sub-stage ----------------
	logic               dv_v_s4   [QW];
	flags_t             dv_f_s4   [QW];
	logic [STIFF_W-1:0] dv_w_s4   [QW];
	logic [NUM_W-1:0]   dv_rem_s4 [QW];
	logic [QW-1:0]      dv_q_s4   [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;   // quotient bit settled here

		logic               v_in;
		flags_t             f_in;
		logic [STIFF_W-1:0] w_in;
		logic [NUM_W-1:0]   rem_in;
		logic [QW-1:0]      q_in;
		logic [NUM_W-1:0]   dvs;
		logic               take;

		if (j == 0) begin : g_first
			assign v_in   = v_s3;
			assign f_in   = f_s3;
			assign w_in   = w_s3;
			assign rem_in = rem_s3;
			assign q_in   = '0;
		end else begin : g_next
			assign v_in   = dv_v_s4[j-1];
			assign f_in   = dv_f_s4[j-1];
			assign w_in   = dv_w_s4[j-1];
			assign rem_in = dv_rem_s4[j-1];
			assign q_in   = dv_q_s4[j-1];
		end

		assign dvs  = NUM_W'(w_in) << (SH + K);
		assign take = (rem_in >= dvs);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s4[j] <= 1'b0;
			end else if (adv) begin
				dv_v_s4[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_f_s4[j]   <= f_in;
				dv_w_s4[j]   <= w_in;
				dv_rem_s4[j] <= take ? (rem_in - dvs) : rem_in;
				dv_q_s4[j]   <= q_in | (QW'(take) << K);
			end
		end
	end

	// ---------------- Stage 5: pick curve branch ----------------
	logic [QW-1:0] r16_c;
	logic          lo_c;
	assign r16_c = dv_q_s4[QW-1];
	assign lo_c  = !r16_c[QW-1];

	logic          v_s5;
	flags_t        f_s5;
	logic [QW-1:0] x_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= dv_v_s4[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s5.zero <= dv_f_s4[QW-1].zero;
			f_s5.sat  <= dv_f_s4[QW-1].sat;
			f_s5.ovf  <= dv_f_s4[QW-1].ovf;
			f_s5.lo   <= lo_c;
			// Distance below 2.0 on the upper branch.
			x_s5      <= lo_c ? r16_c : (QW'(0) - r16_c);
		end
	end

	// ---------------- Stage 6: square ----------------
	logic            v_s6;
	flags_t          f_s6;
	logic [SQ_W-1:0] sq_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s6  <= f_s5;
			sq_s6 <= SQ_W'(x_s5) * SQ_W'(x_s5);
		end
	end

	// ---------------- Stage 7: apply 0.45 gain ----------------
	logic              v_s7;
	flags_t            f_s7;
	logic [PROD_W-1:0] p_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s7 <= f_s6;
			p_s7 <= PROD_W'(sq_s6) * PROD_W'(CURVE_GAIN);
		end
	end

	// ---------------- Stage 8: whole percent, output register ----------------
	logic [STIFF_W-1:0] t_floor_c;
	logic [STIFF_W-1:0] t_ceil_c;
	logic [STIFF_W-1:0] res_c;

	assign t_floor_c = STIFF_W'(p_s7[PROD_W-1:32]);
	assign t_ceil_c  = t_floor_c + STIFF_W'(|p_s7[31:0]);

	always_comb begin
		if (f_s7.zero) begin
			res_c = STIFF_LIMP;
		end else if (f_s7.sat || f_s7.ovf) begin
			res_c = STIFF_FULL;
		end else if (f_s7.lo) begin
			res_c = STIFF_FLOOR + t_floor_c;
		end else begin
			res_c = STIFF_FULL - t_ceil_c;
		end
	end

	logic               v_s8;
	logic [STIFF_W-1:0] res_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s8 <= res_c;
		end
	end

	assign out_valid         = v_s8;
	assign applied_stiffness = res_s8;

	// ---------------- Assertions ----------------
	// Divider leaves a remainder below the Q16 divisor on live items.
	`JDS_ASSERT_IMPLY(a_div_rem_bound, dv_v_s4[QW-1] && !dv_f_s4[QW-1].sat && !dv_f_s4[QW-1].ovf, dv_rem_s4[QW-1] < (NUM_W'(dv_w_s4[QW-1]) << SH), "divider remainder not below divisor")
	// Curve distance never exceeds 1.0 in Q16.
	`JDS_ASSERT_IMPLY(a_curve_x_range, v_s5 && !f_s5.zero && !f_s5.sat && !f_s5.ovf, x_s5 <= (QW'(1) << (QW - 1)), "curve operand out of range")
	// A held pipeline keeps its first stage occupied.
	`JDS_ASSERT_NEXT(a_stall_holds, v_s1 && !adv, v_s1, "stage 1 item lost during stall")

endmodule

`default_nettype wire
